// ===== design/fct_pkg.sv =====
// Shared types and constants of the frustum cull test block.
package fct_pkg;

    localparam int NUM_PLANES = 6;
    localparam int NUM_STAGES = 5;
    localparam int PLANE_W    = 63;
    localparam int NORM_W     = 13;
    localparam int COORD_W    = 24;
    localparam int RADIUS_W   = 23;
    localparam int CFG_IDX_W  = 3;

    localparam int NX_LSB = 0;
    localparam int NY_LSB = 13;
    localparam int NZ_LSB = 26;
    localparam int D_LSB  = 39;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_FAR    = 3'd5;

    localparam logic OP_BOX    = 1'b0;
    localparam logic OP_SPHERE = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic signed [COORD_W-1:0]  lo_x;
        logic signed [COORD_W-1:0]  lo_y;
        logic signed [COORD_W-1:0]  lo_z;
        logic signed [COORD_W-1:0]  hi_x;
        logic signed [COORD_W-1:0]  hi_y;
        logic signed [COORD_W-1:0]  hi_z;
        logic        [RADIUS_W-1:0] radius;
    } t_in_word;

    typedef struct packed {
        logic visible;
    } t_out_word;

    typedef struct packed {
        logic load_s1;
        logic load_s2;
        logic load_s3;
        logic load_s4;
        logic load_out;
    } t_pipe_ctl;

endpackage

// ===== design/fct_in_if.sv =====
// Input channel carrying one bounding volume word.
interface fct_in_if;
    logic              valid;
    logic              ready;
    fct_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/fct_out_if.sv =====
// Output channel carrying one visibility result word.
interface fct_out_if;
    logic               valid;
    logic               ready;
    fct_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/fct_pipe_ctrl.sv =====
// Valid bits and per-stage load enables of the cull pipeline.
module fct_pipe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fct_pkg::t_pipe_ctl o_ctl
);
    import fct_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES:0]   w_en;
    logic                  w_in_fire;
    logic                  w_out_fire;

    always_comb begin
        w_en[NUM_STAGES] = i_out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        if (w_en[0]) begin
            n_vld[0] = i_in_valid;
        end else begin
            n_vld[0] = r_vld[0];
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_in_fire  = i_in_valid && w_en[0];
    assign w_out_fire = r_vld[NUM_STAGES-1] && i_out_ready;

    assign o_in_ready     = w_en[0];
    assign o_out_valid    = r_vld[NUM_STAGES-1];
    assign o_ctl.load_s1  = w_en[0];
    assign o_ctl.load_s2  = w_en[1];
    assign o_ctl.load_s3  = w_en[2];
    assign o_ctl.load_s4  = w_en[3];
    assign o_ctl.load_out = w_en[4];

`ifndef SYNTH
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_in_fire && !w_out_fire) |=> $countones(r_vld) == $past($countones(r_vld)))
        else $error("Words in flight changed without a handshake.");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !w_out_fire) |=> $countones(r_vld) == $past($countones(r_vld)) + 1)
        else $error("Accepted word was not added to the pipeline.");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && !w_in_fire) |=> $countones(r_vld) == $past($countones(r_vld)) - 1)
        else $error("Delivered word was not removed from the pipeline.");
`endif

endmodule

// ===== design/fct_plane_lane.sv =====
// Four-stage test of one volume against one plane: corner pick, products, partial sums, sign.
module fct_plane_lane (
    input  logic                         i_clk,
    input  fct_pkg::t_pipe_ctl           i_ctl,
    input  fct_pkg::t_in_word            i_word,
    input  logic [fct_pkg::PLANE_W-1:0]  i_plane,
    output logic                         o_cull
);
    import fct_pkg::*;

    localparam int OFF_W  = COORD_W + 1;
    localparam int PROD_W = NORM_W + COORD_W;
    localparam int PART_W = PROD_W + 1;
    localparam int SUM_W  = PART_W + 1;

    logic signed [NORM_W-1:0]  w_nx;
    logic signed [NORM_W-1:0]  w_ny;
    logic signed [NORM_W-1:0]  w_nz;
    logic signed [COORD_W-1:0] w_d;
    logic                      w_box;

    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic signed [COORD_W-1:0] r_cz;
    logic signed [OFF_W-1:0]   r_off1;

    logic signed [PROD_W-1:0]  r_px;
    logic signed [PROD_W-1:0]  r_py;
    logic signed [PROD_W-1:0]  r_pz;
    logic signed [OFF_W-1:0]   r_off2;

    logic signed [PART_W-1:0]  r_sa;
    logic signed [PART_W-1:0]  r_sb;
    logic signed [SUM_W-1:0]   n_sum;
    logic                      r_cull;

    assign w_nx  = signed'(i_plane[NX_LSB +: NORM_W]);
    assign w_ny  = signed'(i_plane[NY_LSB +: NORM_W]);
    assign w_nz  = signed'(i_plane[NZ_LSB +: NORM_W]);
    assign w_d   = signed'(i_plane[D_LSB +: COORD_W]);
    assign w_box = (i_word.operation == OP_BOX);

    // A box is tested at the corner furthest along the normal; a sphere at its center.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s1) begin
            r_cx   <= (w_box && w_nx > 0) ? i_word.hi_x : i_word.lo_x;
            r_cy   <= (w_box && w_ny > 0) ? i_word.hi_y : i_word.lo_y;
            r_cz   <= (w_box && w_nz > 0) ? i_word.hi_z : i_word.lo_z;
            r_off1 <= OFF_W'(w_d) + (w_box ? '0 : signed'({2'b00, i_word.radius}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s2) begin
            r_px   <= PROD_W'(w_nx) * PROD_W'(r_cx);
            r_py   <= PROD_W'(w_ny) * PROD_W'(r_cy);
            r_pz   <= PROD_W'(w_nz) * PROD_W'(r_cz);
            r_off2 <= r_off1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s3) begin
            r_sa <= PART_W'(r_px) + PART_W'(r_py);
            r_sb <= PART_W'(r_pz) + PART_W'(signed'({r_off2, 11'b0}));
        end
    end

    assign n_sum = SUM_W'(r_sa) + SUM_W'(r_sb);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s4) begin
            r_cull <= n_sum[SUM_W-1];
        end
    end

    assign o_cull = r_cull;

endmodule

// ===== design/frustum_cull_test.sv =====
// Top level of the frustum cull test: plane registers, six plane lanes and the result register.
//
// The block takes one bounding volume word per cycle while the output side does not stall,
// and returns one visibility word per volume, in order. Each of the six planes has its own
// lane of four register stages (corner pick, three 13 by 24 bit products, two partial sums,
// final sum and sign), and the result register ANDs the six lanes; the product stage sets
// the clock. A stalled output fills empty stages first and then holds the whole pipeline.
// Planes must be written by the user through the configuration port only while no word is in
// flight; the block itself does not enforce this. A write to an index above five is ignored.
module frustum_cull_test (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fct_in_if.sink                         i_cull,
    fct_out_if.source                      o_cull,
    input  logic                           i_cfg_wr_en,
    input  logic [fct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fct_pkg::PLANE_W-1:0]    i_cfg_wdata
);
    import fct_pkg::*;

    logic [PLANE_W-1:0]    r_plane [NUM_PLANES];
    logic [NUM_PLANES-1:0] w_cull;
    logic                  r_visible;
    t_pipe_ctl             w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_plane[p] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PLANE_LEFT:   r_plane[0] <= i_cfg_wdata;
                CFG_PLANE_RIGHT:  r_plane[1] <= i_cfg_wdata;
                CFG_PLANE_BOTTOM: r_plane[2] <= i_cfg_wdata;
                CFG_PLANE_TOP:    r_plane[3] <= i_cfg_wdata;
                CFG_PLANE_NEAR:   r_plane[4] <= i_cfg_wdata;
                CFG_PLANE_FAR:    r_plane[5] <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    fct_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cull.valid),
        .o_in_ready  (i_cull.ready),
        .o_out_valid (o_cull.valid),
        .i_out_ready (o_cull.ready),
        .o_ctl       (w_ctl)
    );

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
        fct_plane_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_word  (i_cull.data),
            .i_plane (r_plane[p]),
            .o_cull  (w_cull[p])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load_out) begin
            r_visible <= ~|w_cull;
        end
    end

    assign o_cull.data.visible = r_visible;

endmodule

// ===== dv/frustum_cull_test_tb.sv =====
// Self-checking testbench of the frustum cull test block: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
    import fct_pkg::*;

    localparam int NO_TYPED    = -1;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 200;
    localparam int HOLD_LEN    = 300;
    localparam int C_MAX       = 8388607;
    localparam int C_MIN       = -8388608;
    localparam int N_MAX       = 4095;
    localparam int N_MIN       = -4096;

    localparam logic [CFG_IDX_W-1:0] CFG_PAST_LAST_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PAST_LAST_B = 3'd7;
    localparam logic [CFG_IDX_W-1:0] PLANE_IDX [NUM_PLANES] = '{
        CFG_PLANE_LEFT, CFG_PLANE_RIGHT, CFG_PLANE_BOTTOM,
        CFG_PLANE_TOP, CFG_PLANE_NEAR, CFG_PLANE_FAR
    };

    typedef enum int {PS_RESET, PS_FAR_ONLY, PS_CUBE, PS_EXTREME} t_plane_set;
    typedef enum int {PK_FRUSTUM, PK_RANDOM, PK_EXTREME} t_plane_kind;

    typedef struct {
        t_plane_set planes_sel;
        t_in_word   w;
        int         typed;
    } t_dir_row;

    localparam t_plane_kind PHASE_KIND [PHASES] = '{
        PK_FRUSTUM, PK_EXTREME, PK_FRUSTUM, PK_RANDOM,
        PK_FRUSTUM, PK_EXTREME, PK_RANDOM, PK_FRUSTUM
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PLANE_W-1:0] i_cfg_wdata;

    fct_in_if  cull_in ();
    fct_out_if cull_out ();

    frustum_cull_test u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cull      (cull_in),
        .o_cull      (cull_out),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [PLANE_W-1:0] planes [NUM_PLANES];
    logic pending_visible [$];
    t_dir_row dir_rows [$];
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
        logic [PLANE_W-1:0] p;
        p = '0;
        p[NX_LSB +: NORM_W] = nx[NORM_W-1:0];
        p[NY_LSB +: NORM_W] = ny[NORM_W-1:0];
        p[NZ_LSB +: NORM_W] = nz[NORM_W-1:0];
        p[D_LSB +: COORD_W] = d[COORD_W-1:0];
        return p;
    endfunction

    function automatic t_in_word make_word(logic op, int lx, int ly, int lz,
                                           int hx, int hy, int hz, int r);
        t_in_word w;
        w.operation = op;
        w.lo_x = lx[COORD_W-1:0];
        w.lo_y = ly[COORD_W-1:0];
        w.lo_z = lz[COORD_W-1:0];
        w.hi_x = hx[COORD_W-1:0];
        w.hi_y = hy[COORD_W-1:0];
        w.hi_z = hz[COORD_W-1:0];
        w.radius = r[RADIUS_W-1:0];
        return w;
    endfunction

    function automatic logic predict_visible(t_in_word w);
        logic signed [NORM_W-1:0] fx, fy, fz;
        logic signed [COORD_W-1:0] fd;
        longint nx, ny, nz, dd, cx, cy, cz, s;
        logic vis;
        vis = 1'b1;
        for (int i = 0; i < NUM_PLANES; i++) begin
            fx = planes[i][NX_LSB +: NORM_W];
            fy = planes[i][NY_LSB +: NORM_W];
            fz = planes[i][NZ_LSB +: NORM_W];
            fd = planes[i][D_LSB +: COORD_W];
            nx = fx;
            ny = fy;
            nz = fz;
            dd = fd;
            if (w.operation == OP_SPHERE) begin
                cx = longint'(signed'(w.lo_x));
                cy = longint'(signed'(w.lo_y));
                cz = longint'(signed'(w.lo_z));
                dd = dd + longint'({1'b0, w.radius});
            end else begin
                cx = (nx > 0) ? longint'(signed'(w.hi_x)) : longint'(signed'(w.lo_x));
                cy = (ny > 0) ? longint'(signed'(w.hi_y)) : longint'(signed'(w.lo_y));
                cz = (nz > 0) ? longint'(signed'(w.hi_z)) : longint'(signed'(w.lo_z));
            end
            s = nx * cx + ny * cy + nz * cz + dd * 2048;
            if (s < 0) begin
                vis = 1'b0;
            end
        end
        return vis;
    endfunction

    function automatic int pick_of3(int a, int b, int c);
        case ($urandom_range(2))
            0: return a;
            1: return b;
            default: return c;
        endcase
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic fill_directed_planes(t_plane_set sel);
        for (int i = 0; i < NUM_PLANES; i++) begin
            planes[i] = '0;
        end
        case (sel)
            PS_FAR_ONLY: begin
                planes[5] = pack_plane(0, 0, 0, -1);
            end
            PS_CUBE: begin
                planes[0] = pack_plane(2048, 0, 0, 25600);
                planes[1] = pack_plane(-2048, 0, 0, 25600);
                planes[2] = pack_plane(0, 2048, 0, 25600);
                planes[3] = pack_plane(0, -2048, 0, 25600);
                planes[4] = pack_plane(0, 0, 2048, 25600);
                planes[5] = pack_plane(0, 0, -2048, 25600);
            end
            PS_EXTREME: begin
                planes[0] = pack_plane(N_MAX, N_MAX, N_MAX, C_MAX);
                planes[1] = pack_plane(N_MIN, N_MIN, N_MIN, C_MAX);
                planes[2] = pack_plane(0, N_MAX, N_MIN, 0);
                planes[3] = pack_plane(N_MAX, 0, 0, C_MIN);
                planes[4] = pack_plane(N_MIN, 0, N_MAX, -1);
                planes[5] = pack_plane(0, 0, 0, C_MAX);
            end
            default: ;
        endcase
    endtask

    task automatic fill_random_planes(t_plane_kind kind);
        int comp [3];
        int sgn;
        for (int i = 0; i < NUM_PLANES; i++) begin
            case (kind)
                PK_FRUSTUM: begin
                    sgn = (i % 2 == 0) ? 1 : -1;
                    for (int a = 0; a < 3; a++) begin
                        comp[a] = jitter(600);
                    end
                    comp[i / 2] = sgn * (2048 + jitter(300));
                    planes[i] = pack_plane(comp[0], comp[1], comp[2],
                                           $urandom_range(4194304));
                end
                PK_EXTREME: begin
                    planes[i] = pack_plane(pick_of3(N_MIN, 0, N_MAX), pick_of3(N_MIN, 0, N_MAX),
                                           pick_of3(N_MIN, 0, N_MAX),
                                           pick_of3(C_MIN, C_MAX, jitter(4)));
                end
                default: begin
                    planes[i] = PLANE_W'({$urandom(), $urandom()});
                end
            endcase
        end
    endtask

    task automatic write_planes();
        for (int i = 0; i < NUM_PLANES; i++) begin
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= PLANE_IDX[i];
            i_cfg_wdata <= planes[i];
        end
        @(posedge i_clk);
        i_cfg_index <= CFG_PAST_LAST_A;
        i_cfg_wdata <= PLANE_W'({$urandom(), $urandom()});
        @(posedge i_clk);
        i_cfg_index <= CFG_PAST_LAST_B;
        i_cfg_wdata <= PLANE_W'({$urandom(), $urandom()});
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        cull_in.valid <= 1'b0;
        while (pending_visible.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (NUM_STAGES + 4) @(posedge i_clk);
    endtask

    task automatic send_word(t_in_word w, int typed);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            cull_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        cull_in.valid <= 1'b1;
        cull_in.data <= w;
        do begin
            @(posedge i_clk);
        end while (!cull_in.ready);
        pending_visible.push_back((typed == NO_TYPED) ? predict_visible(w) : typed[0]);
    endtask

    function automatic t_in_word random_word();
        logic [191:0] raw;
        int c [3];
        int e [3];
        t_in_word w;
        if ($urandom_range(9) < 7) begin
            for (int a = 0; a < 3; a++) begin
                c[a] = int'($urandom_range(8388608)) - 4194304;
                e[a] = $urandom_range(2097151);
            end
            if ($urandom_range(19) == 0) begin
                e[$urandom_range(2)] = -int'($urandom_range(2097151));
            end
            w = make_word(1'($urandom_range(1)), c[0] - e[0], c[1] - e[1], c[2] - e[2],
                          c[0] + e[0], c[1] + e[1], c[2] + e[2],
                          $urandom_range(2097151));
        end else begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            w = raw[$bits(t_in_word)-1:0];
        end
        return w;
    endfunction

    task automatic add_row(t_plane_set sel, logic op, int lx, int ly, int lz,
                           int hx, int hy, int hz, int r, int typed);
        t_dir_row row;
        row.planes_sel = sel;
        row.w = make_word(op, lx, ly, lz, hx, hy, hz, r);
        row.typed = typed;
        dir_rows.push_back(row);
    endtask

    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && cull_out.valid && cull_out.ready) begin
            if (pending_visible.size() == 0) begin
                $error("visible: no word expected, actual %0b", cull_out.data.visible);
                fail_count++;
            end else begin
                want = pending_visible.pop_front();
                if (cull_out.data.visible !== want) begin
                    $error("visible: expected %0b, actual %0b", want, cull_out.data.visible);
                    fail_count++;
                end
            end
        end
        if (hold_cycles > 0) begin
            cull_out.ready <= 1'b0;
            hold_cycles--;
        end else begin
            cull_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        t_plane_set cur_sel;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_PLANE_LEFT;
        i_cfg_wdata = '0;
        cull_in.valid = 1'b0;
        cull_in.data = '0;
        cull_out.ready = 1'b0;
        fill_directed_planes(PS_RESET);

        add_row(PS_RESET, OP_BOX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 0, 1);
        add_row(PS_RESET, OP_BOX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0, 1);
        add_row(PS_RESET, OP_BOX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0, 1);
        add_row(PS_RESET, OP_SPHERE, C_MIN, C_MIN, C_MIN, 0, 0, 0, C_MAX, 1);
        add_row(PS_RESET, OP_SPHERE, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0, 1);
        add_row(PS_FAR_ONLY, OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(PS_FAR_ONLY, OP_SPHERE, C_MIN, C_MAX, 0, 0, 0, 0, 1, 1);
        add_row(PS_FAR_ONLY, OP_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, 0);
        add_row(PS_CUBE, OP_BOX, -2560, -2560, -2560, 2560, 2560, 2560, 0, NO_TYPED);
        add_row(PS_CUBE, OP_BOX, 51200, 0, 0, 60000, 10, 10, 0, NO_TYPED);
        add_row(PS_CUBE, OP_BOX, -30000, -30000, 0, 0, 0, 30000, 0, NO_TYPED);
        add_row(PS_CUBE, OP_BOX, 2560, 2560, 2560, -2560, -2560, -2560, 0, NO_TYPED);
        add_row(PS_CUBE, OP_SPHERE, -26880, 0, 0, 0, 0, 0, 2560, NO_TYPED);
        add_row(PS_CUBE, OP_SPHERE, -30000, 0, 0, 0, 0, 0, 1280, NO_TYPED);
        add_row(PS_CUBE, OP_SPHERE, -26880, 0, 0, 0, 0, 0, 1280, NO_TYPED);
        add_row(PS_CUBE, OP_SPHERE, 0, 0, 26880, 0, 0, 0, 1279, NO_TYPED);
        add_row(PS_EXTREME, OP_BOX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 0, NO_TYPED);
        add_row(PS_EXTREME, OP_BOX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0, NO_TYPED);
        add_row(PS_EXTREME, OP_SPHERE, C_MIN, C_MIN, C_MIN, 0, 0, 0, C_MAX, NO_TYPED);
        add_row(PS_EXTREME, OP_SPHERE, C_MAX, C_MAX, C_MAX, 0, 0, 0, C_MAX, NO_TYPED);
        add_row(PS_EXTREME, OP_BOX, C_MIN, 0, C_MIN, C_MAX, 0, C_MAX, 0, NO_TYPED);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cur_sel = PS_RESET;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].planes_sel != cur_sel) begin
                wait_idle();
                cur_sel = dir_rows[k].planes_sel;
                fill_directed_planes(cur_sel);
                write_planes();
            end
            send_word(dir_rows[k].w, dir_rows[k].typed);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            fill_random_planes(PHASE_KIND[p]);
            write_planes();
            send_idle_pct = (p % 4 == 1) ? 88 : (p % 4 == 3) ? 22 : 0;
            recv_stall_pct = (p % 4 == 2) ? 88 : (p % 4 == 3) ? 22 : 0;
            if (p == 4) begin
                hold_cycles = HOLD_LEN;
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_word(random_word(), NO_TYPED);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
